// File: hw/rtl/etu_pkg.sv
// etu_pkg: shared types and constants of the Euler totient unit.
// Used by the sequencer top level, the divider and the checker.
package etu_pkg;

  localparam int WORD_BITS = 32;
  localparam int DIV_BITS  = WORD_BITS / 2 + 1;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int MAX_DIVS  = 9;
  localparam int EMIT_BITS = $clog2(MAX_DIVS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQCHK,
    ST_DIVC,
    ST_DIVT,
    ST_FIN,
    ST_FDIV,
    ST_LAST
  } etu_state_t;

  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] dividend;
    logic [WORD_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] quotient;
    logic [WORD_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

// File: hw/rtl/etu_divider.sv
// etu_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on etu_pkg for widths and the request/response structs.
module etu_divider import etu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [WORD_BITS-1:0] quo_r, quo_nxt;
  logic [WORD_BITS-1:0] dvs_r, dvs_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [WORD_BITS:0]   shifted;
  logic                 fits;

  assign shifted = {rem_r, quo_r[WORD_BITS-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (fits) begin
        rem_nxt = WORD_BITS'(shifted - {1'b0, dvs_r});
      end else begin
        rem_nxt = shifted[WORD_BITS-1:0];
      end
      quo_nxt = {quo_r[WORD_BITS-2:0], fits};
      cnt_nxt = cnt_r + CNT_BITS'(1);
      if (cnt_r == CNT_BITS'(WORD_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// File: hw/rtl/euler_totient_unit.sv
// euler_totient_unit: Euler's totient by trial division under a small sequencer.
// Depends on etu_pkg and etu_divider (shared divider); one shared multiplier.
//
//   channel  handshake            payload
//   request  start & !busy        in_n_value
//   result   out_valid (1 cycle)  out_prime_divisor, out_totient, out_last
//
// Each trial candidate costs one square check and one divide.
// A found divisor adds one divide per division of the cofactor and one for phi.
// A 32-bit prime tests about 32768 candidates; 0, 1 and 2 go straight to the final result.
// Reset is synchronous, active low, and returns the sequencer to idle.
// busy stays high until the final result is issued; results cannot be stalled.
module euler_totient_unit import etu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_BITS-1:0] in_n_value,
  output logic                 out_valid,
  output logic [WORD_BITS-1:0] out_prime_divisor,
  output logic [WORD_BITS-1:0] out_totient,
  output logic                 out_last
);

  etu_state_t state_r, state_nxt;

  logic [WORD_BITS-1:0] c_r, c_nxt;
  logic [WORD_BITS-1:0] t_r, t_nxt;
  logic [DIV_BITS-1:0]  d_r, d_nxt;
  logic                 hit_r, hit_nxt;
  logic                 found_r, found_nxt;
  logic [EMIT_BITS-1:0] cnt_r, cnt_nxt;
  logic                 ov_r, ov_nxt;
  logic [WORD_BITS-1:0] opd_r, opd_nxt;
  logic [WORD_BITS-1:0] otot_r, otot_nxt;
  logic                 olast_r, olast_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [WORD_BITS-1:0]   mul_a, mul_b;
  logic [2*WORD_BITS-1:0] mul_p;
  logic [WORD_BITS-1:0]   d_ext;
  logic                   sq_le, rem_zero, emit_ok, small_n;

  etu_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign d_ext    = WORD_BITS'(d_r);
  assign mul_p    = {{WORD_BITS{1'b0}}, mul_a} * {{WORD_BITS{1'b0}}, mul_b};
  assign sq_le    = mul_p <= {{WORD_BITS{1'b0}}, c_r};
  assign rem_zero = div_rsp.remainder == '0;
  assign emit_ok  = cnt_r < EMIT_BITS'(MAX_DIVS);
  assign small_n  = in_n_value <= WORD_BITS'(2);

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_SQCHK: begin
        mul_a = d_ext;
        mul_b = d_ext;
      end
      ST_DIVT: begin
        mul_a = div_rsp.quotient;
        mul_b = d_ext - WORD_BITS'(1);
      end
      default: begin
        mul_a = div_rsp.quotient;
        mul_b = c_r - WORD_BITS'(1);
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = small_n ? ST_LAST : ST_SQCHK;
      end
      ST_SQCHK: state_nxt = sq_le ? ST_DIVC : ST_FIN;
      ST_DIVC: begin
        if (div_rsp.done) begin
          if (!rem_zero) state_nxt = ST_SQCHK;
          else if (!hit_r) state_nxt = ST_DIVT;
        end
      end
      ST_DIVT: begin
        if (div_rsp.done) state_nxt = ST_DIVC;
      end
      ST_FIN: begin
        if (found_r && c_r > WORD_BITS'(1)) state_nxt = ST_FDIV;
        else state_nxt = ST_LAST;
      end
      ST_FDIV: begin
        if (div_rsp.done) state_nxt = ST_LAST;
      end
      ST_LAST: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    c_nxt            = c_r;
    t_nxt            = t_r;
    d_nxt            = d_r;
    hit_nxt          = hit_r;
    found_nxt        = found_r;
    cnt_nxt          = cnt_r;
    ov_nxt           = 1'b0;
    opd_nxt          = opd_r;
    otot_nxt         = otot_r;
    olast_nxt        = olast_r;
    div_req.start    = 1'b0;
    div_req.dividend = c_r;
    div_req.divisor  = d_ext;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          c_nxt     = in_n_value;
          d_nxt     = DIV_BITS'(2);
          found_nxt = 1'b0;
          cnt_nxt   = '0;
          if (in_n_value == '0) t_nxt = '0;
          else if (small_n) t_nxt = WORD_BITS'(1);
          else t_nxt = in_n_value;
        end
      end
      ST_SQCHK: begin
        hit_nxt = 1'b0;
        if (sq_le) div_req.start = 1'b1;
      end
      ST_DIVC: begin
        if (div_rsp.done) begin
          if (rem_zero) begin
            c_nxt         = div_rsp.quotient;
            div_req.start = 1'b1;
            if (!hit_r) begin
              hit_nxt          = 1'b1;
              found_nxt        = 1'b1;
              div_req.dividend = t_r;
              if (emit_ok) begin
                ov_nxt    = 1'b1;
                opd_nxt   = d_ext;
                otot_nxt  = '0;
                olast_nxt = 1'b0;
                cnt_nxt   = cnt_r + EMIT_BITS'(1);
              end
            end else begin
              div_req.dividend = div_rsp.quotient;
            end
          end else begin
            d_nxt = (d_r == DIV_BITS'(2)) ? DIV_BITS'(3) : d_r + DIV_BITS'(2);
          end
        end
      end
      ST_DIVT: begin
        if (div_rsp.done) begin
          t_nxt         = mul_p[WORD_BITS-1:0];
          div_req.start = 1'b1;
        end
      end
      ST_FIN: begin
        if (!found_r) begin
          t_nxt = c_r - WORD_BITS'(1);
        end else if (c_r > WORD_BITS'(1)) begin
          div_req.start    = 1'b1;
          div_req.dividend = t_r;
          div_req.divisor  = c_r;
          if (emit_ok) begin
            ov_nxt    = 1'b1;
            opd_nxt   = c_r;
            otot_nxt  = '0;
            olast_nxt = 1'b0;
            cnt_nxt   = cnt_r + EMIT_BITS'(1);
          end
        end
      end
      ST_FDIV: begin
        if (div_rsp.done) t_nxt = mul_p[WORD_BITS-1:0];
      end
      ST_LAST: begin
        ov_nxt    = 1'b1;
        opd_nxt   = '0;
        otot_nxt  = t_r;
        olast_nxt = 1'b1;
      end
      default: begin
        ov_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      hit_r   <= 1'b0;
      found_r <= 1'b0;
      cnt_r   <= '0;
      c_r     <= '0;
      t_r     <= '0;
      d_r     <= DIV_BITS'(2);
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      hit_r   <= hit_nxt;
      found_r <= found_nxt;
      cnt_r   <= cnt_nxt;
      c_r     <= c_nxt;
      t_r     <= t_nxt;
      d_r     <= d_nxt;
    end
    opd_r   <= opd_nxt;
    otot_r  <= otot_nxt;
    olast_r <= olast_nxt;
  end

  assign busy              = state_r != ST_IDLE;
  assign out_valid         = ov_r;
  assign out_prime_divisor = opd_r;
  assign out_totient       = otot_r;
  assign out_last          = olast_r;

endmodule

// File: hw/rtl/etu_checker.sv
// etu_checker: port-level assertions for euler_totient_unit, bound to the top.
// Depends on etu_pkg for the word width.
module etu_checker import etu_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [WORD_BITS-1:0] in_n_value,
  input logic                 out_valid,
  input logic [WORD_BITS-1:0] out_prime_divisor,
  input logic [WORD_BITS-1:0] out_totient,
  input logic                 out_last
);

  // accepted request keeps the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_req_known: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> !$isunknown(in_n_value))
    else $error("request accepted with unknown operand");

  // results never come in adjacent cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // divisor results only while the request is still in work, with a zero totient
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy && out_totient == '0)
    else $error("divisor result outside work or with nonzero totient");

  a_final_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_prime_divisor == '0)
    else $error("final result carries a divisor");

endmodule

bind euler_totient_unit etu_checker u_etu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_n_value        (in_n_value),
  .out_valid         (out_valid),
  .out_prime_divisor (out_prime_divisor),
  .out_totient       (out_totient),
  .out_last          (out_last)
);
